FILE: sv/position_keyed_affine_byte_cipher_assert.svh
// Assertion macros for the position keyed affine byte cipher.
`ifndef POSITION_KEYED_AFFINE_BYTE_CIPHER_ASSERT_SVH
`define POSITION_KEYED_AFFINE_BYTE_CIPHER_ASSERT_SVH

`ifndef SYNTHESIS
`define PKABC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PKABC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PKABC_ASSERT(lbl, prop, msg)
`define PKABC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: sv/pkabc_pkg.sv
// Shared types, constants and the odd inverse table for the byte cipher.
package pkabc_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [1:0] REG_SLOPE     = 2'd0;
  localparam logic [1:0] REG_INTERCEPT = 2'd1;
  localparam logic [1:0] REG_MODE      = 2'd2;

  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  localparam logic [7:0] SLOPE_RESET = 8'd1;

  localparam logic [7:0] ODD_INV [128] = '{
    8'd1,   8'd171, 8'd205, 8'd183, 8'd57,  8'd163, 8'd197, 8'd239,
    8'd241, 8'd27,  8'd61,  8'd167, 8'd41,  8'd19,  8'd53,  8'd223,
    8'd225, 8'd139, 8'd173, 8'd151, 8'd25,  8'd131, 8'd165, 8'd207,
    8'd209, 8'd251, 8'd29,  8'd135, 8'd9,   8'd243, 8'd21,  8'd191,
    8'd193, 8'd107, 8'd141, 8'd119, 8'd249, 8'd99,  8'd133, 8'd175,
    8'd177, 8'd219, 8'd253, 8'd103, 8'd233, 8'd211, 8'd245, 8'd159,
    8'd161, 8'd75,  8'd109, 8'd87,  8'd217, 8'd67,  8'd101, 8'd143,
    8'd145, 8'd187, 8'd221, 8'd71,  8'd201, 8'd179, 8'd213, 8'd127,
    8'd129, 8'd43,  8'd77,  8'd55,  8'd185, 8'd35,  8'd69,  8'd111,
    8'd113, 8'd155, 8'd189, 8'd39,  8'd169, 8'd147, 8'd181, 8'd95,
    8'd97,  8'd11,  8'd45,  8'd23,  8'd153, 8'd3,   8'd37,  8'd79,
    8'd81,  8'd123, 8'd157, 8'd7,   8'd137, 8'd115, 8'd149, 8'd63,
    8'd65,  8'd235, 8'd13,  8'd247, 8'd121, 8'd227, 8'd5,   8'd47,
    8'd49,  8'd91,  8'd125, 8'd231, 8'd105, 8'd83,  8'd117, 8'd31,
    8'd33,  8'd203, 8'd237, 8'd215, 8'd89,  8'd195, 8'd229, 8'd15,
    8'd17,  8'd59,  8'd93,  8'd199, 8'd73,  8'd51,  8'd85,  8'd255
  };

  // Work for the back end: result = mul_a * mul_b + addend, mod 256.
  typedef struct packed {
    logic [7:0] mul_a;
    logic [7:0] mul_b;
    logic [7:0] addend;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [7:0] odd_inverse(input logic [7:0] m);
    return ODD_INV[m[7:1]];
  endfunction

endpackage

FILE: sv/pkabc_front.sv
// Front end: config registers, position count and operand preparation.
module pkabc_front import pkabc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [1:0]    wr_index,
  input  logic [7:0]    wr_data,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    data_byte,
  input  logic          start_of_stream,
  input  queue_status_t status,
  output logic          push,
  output op_t           op
);

  logic [7:0] slope;
  logic [7:0] intercept;
  logic       mode;
  logic [7:0] position;

  logic [7:0] p;
  logic [7:0] m;
  logic [7:0] diff;

  assign in_stall = status.full;
  assign push     = in_valid && !status.full;

  assign p    = start_of_stream ? 8'd0 : position;
  assign m    = slope + {p[6:0], 1'b0};
  assign diff = data_byte - intercept - p;

  always_comb begin
    if (mode == MODE_DECRYPT) begin
      op.mul_a  = odd_inverse(m);
      op.mul_b  = diff;
      op.addend = 8'd0;
    end else begin
      op.mul_a  = data_byte;
      op.mul_b  = m;
      op.addend = intercept + p;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slope     <= SLOPE_RESET;
      intercept <= 8'd0;
      mode      <= MODE_ENCRYPT;
      position  <= 8'd0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_SLOPE:     slope     <= wr_data | 8'd1;
          REG_INTERCEPT: intercept <= wr_data;
          REG_MODE:      mode      <= wr_data[0];
          default:       ;
        endcase
      end
      if (push) begin
        position <= p + 8'd1;
      end
    end
  end

endmodule

FILE: sv/pkabc_queue.sv
// Short queue of prepared operands between front and back end.
module pkabc_queue import pkabc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  op_t           push_op,
  input  logic          pop,
  output op_t           pop_op,
  output queue_status_t status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  op_t           entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign status.full  = (count == CW'(DEPTH));
  assign status.empty = (count == '0);
  assign pop_op       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

`include "position_keyed_affine_byte_cipher_assert.svh"

  `PKABC_ASSERT(a_count_bound, count <= CW'(DEPTH), "queue count above depth")
  `PKABC_ASSERT(a_push_grows, push && !pop |=> count == $past(count) + 1'b1, "push lost")
  `PKABC_ASSERT(a_pop_shrinks, pop && !push |=> count == $past(count) - 1'b1, "pop lost")
  `PKABC_ASSERT_ALWAYS(a_reset_empty, rst |=> count == '0, "queue not empty after reset")

endmodule

FILE: sv/pkabc_back.sv
// Back end: multiply-add and output register.
module pkabc_back import pkabc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  queue_status_t status,
  input  op_t           op,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    result_byte
);

  logic [15:0] prod;

  assign pop  = !status.empty && (!out_valid || !out_stall);
  assign prod = 16'(op.mul_a) * 16'(op.mul_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result_byte <= prod[7:0] + op.addend;
    end
  end

endmodule

FILE: sv/position_keyed_affine_byte_cipher.sv
// Position keyed affine byte cipher, top level.
// Throughput: one byte per cycle, sustained, with no idle cycles, while out_stall is low and the queue is not full.
// Each accepted byte passes through its queue entry and then the output register before its result is valid.
// The queue (QUEUE_DEPTH items) absorbs output stall; input stalls only when it is full.
// Reset: slope 1, intercept 0, encrypt mode, position 0, queue and output empty.
module position_keyed_affine_byte_cipher import pkabc_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  logic [1:0] wr_index,
  input  logic [7:0] wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       start_of_stream,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] result_byte
);

  queue_status_t status;
  logic          push;
  logic          pop;
  op_t           push_op;
  op_t           pop_op;

  pkabc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .wr_en           (wr_en),
    .wr_index        (wr_index),
    .wr_data         (wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .data_byte       (data_byte),
    .start_of_stream (start_of_stream),
    .status          (status),
    .push            (push),
    .op              (push_op)
  );

  pkabc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .pop_op  (pop_op),
    .status  (status)
  );

  pkabc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .status      (status),
    .op          (pop_op),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_byte (result_byte)
  );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the position keyed affine byte cipher.
`timescale 1ns / 1ps

module tb_top;
  import pkabc_pkg::*;

  localparam logic [1:0] REG_NONE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [1:0] idx;
    logic [7:0] val;
    logic       sos;
    logic       has_exp;
    logic [7:0] exp;
  } row_t;

  localparam int NUM_ROWS = 33;
  localparam row_t DIRECTED [NUM_ROWS] = '{
    '{ROW_ITEM,  REG_SLOPE,     8'h00, 1'b0, 1'b1, 8'h00},
    '{ROW_ITEM,  REG_SLOPE,     8'hFF, 1'b0, 1'b1, 8'hFE},
    '{ROW_ITEM,  REG_SLOPE,     8'h07, 1'b1, 1'b1, 8'h07},
    '{ROW_ITEM,  REG_SLOPE,     8'h80, 1'b0, 1'b1, 8'h81},
    '{ROW_ITEM,  REG_SLOPE,     8'h5A, 1'b0, 1'b0, 8'h00},
    '{ROW_WRITE, REG_SLOPE,     8'hFE, 1'b0, 1'b0, 8'h00},
    '{ROW_WRITE, REG_INTERCEPT, 8'hFF, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM,  REG_SLOPE,     8'hFF, 1'b1, 1'b1, 8'h00},
    '{ROW_ITEM,  REG_SLOPE,     8'h01, 1'b0, 1'b1, 8'h01},
    '{ROW_ITEM,  REG_SLOPE,     8'h00, 1'b0, 1'b1, 8'h01},
    '{ROW_ITEM,  REG_SLOPE,     8'hC3, 1'b0, 1'b0, 8'h00},
    '{ROW_WRITE, REG_MODE,      8'hFF, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM,  REG_SLOPE,     8'h00, 1'b1, 1'b1, 8'hFF},
    '{ROW_ITEM,  REG_SLOPE,     8'h00, 1'b0, 1'b1, 8'h00},
    '{ROW_ITEM,  REG_SLOPE,     8'hFF, 1'b0, 1'b1, 8'hAA},
    '{ROW_ITEM,  REG_SLOPE,     8'h3C, 1'b0, 1'b0, 8'h00},
    '{ROW_WRITE, REG_NONE,      8'h00, 1'b0, 1'b0, 8'h00},
    '{ROW_WRITE, REG_NONE,      8'hFF, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM,  REG_SLOPE,     8'h00, 1'b1, 1'b1, 8'hFF},
    '{ROW_WRITE, REG_MODE,      8'hFE, 1'b0, 1'b0, 8'h00},
    '{ROW_WRITE, REG_SLOPE,     8'h00, 1'b0, 1'b0, 8'h00},
    '{ROW_WRITE, REG_INTERCEPT, 8'h00, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM,  REG_SLOPE,     8'h00, 1'b1, 1'b1, 8'h00},
    '{ROW_ITEM,  REG_SLOPE,     8'hFF, 1'b0, 1'b1, 8'hFE},
    '{ROW_ITEM,  REG_SLOPE,     8'h96, 1'b1, 1'b0, 8'h00},
    '{ROW_ITEM,  REG_SLOPE,     8'h69, 1'b0, 1'b0, 8'h00},
    '{ROW_WRITE, REG_MODE,      8'h01, 1'b0, 1'b0, 8'h00},
    '{ROW_WRITE, REG_SLOPE,     8'h80, 1'b0, 1'b0, 8'h00},
    '{ROW_WRITE, REG_INTERCEPT, 8'h80, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM,  REG_SLOPE,     8'h80, 1'b1, 1'b1, 8'h00},
    '{ROW_ITEM,  REG_SLOPE,     8'hA5, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM,  REG_SLOPE,     8'h5A, 1'b0, 1'b0, 8'h00},
    '{ROW_ITEM,  REG_SLOPE,     8'hE1, 1'b0, 1'b0, 8'h00}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       wr_en = 1'b0;
  logic [1:0] wr_index = REG_SLOPE;
  logic [7:0] wr_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = 8'h00;
  logic       start_of_stream = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] result_byte;

  logic [7:0] cur_slope = SLOPE_RESET;
  logic [7:0] cur_intercept = 8'h00;
  logic       cur_mode = MODE_ENCRYPT;
  logic [7:0] pos_next = 8'h00;

  logic [7:0]  expected_bytes [$];
  logic [7:0]  want;
  logic        idle_on = 1'b1;
  int unsigned cycle_count = 0;
  int unsigned errors = 0;

  position_keyed_affine_byte_cipher dut (
    .clk             (clk),
    .rst             (rst),
    .wr_en           (wr_en),
    .wr_index        (wr_index),
    .wr_data         (wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .data_byte       (data_byte),
    .start_of_stream (start_of_stream),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .result_byte     (result_byte)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [7:0] inv_mod256(input logic [7:0] m);
    logic [7:0] k8;
    for (int k = 1; k < 256; k += 2) begin
      k8 = k[7:0];
      if (8'(k8 * m) == 8'd1) return k8;
    end
    return 8'd0;
  endfunction

  // Updates the stream position as a side effect.
  function automatic logic [7:0] cipher_byte(input logic [7:0] b, input logic sos);
    logic [7:0] p;
    logic [7:0] m;
    logic [7:0] r;
    p = sos ? 8'd0 : pos_next;
    m = cur_slope + {p[6:0], 1'b0};
    if (cur_mode == MODE_ENCRYPT) begin
      r = b * m + cur_intercept + p;
    end else begin
      r = inv_mod256(m) * (b - cur_intercept - p);
    end
    pos_next = p + 8'd1;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    $display("MISMATCH cycle %0d: %s", cycle_count, what);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      REG_SLOPE:     cur_slope = val | 8'd1;
      REG_INTERCEPT: cur_intercept = val;
      REG_MODE:      cur_mode = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic sos,
                           input logic use_typed, input logic [7:0] typed);
    logic [7:0] predicted;
    while (idle_on && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    start_of_stream <= sos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = cipher_byte(b, sos);
    expected_bytes.push_back(use_typed ? typed : predicted);
  endtask

  task automatic await_drain();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_stall <= idle_on && ($urandom_range(99) < 30);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("result_byte %02h with no item pending", result_byte));
      end else begin
        want = expected_bytes.pop_front();
        if (result_byte !== want) begin
          report_mismatch($sformatf("result_byte %02h, expected %02h", result_byte, want));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int unsigned total;
    int unsigned sent;
    int unsigned len;
    logic        noisy;
    logic        sos;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_WRITE) begin
        await_drain();
        cfg_write(DIRECTED[i].idx, DIRECTED[i].val);
      end else begin
        push_byte(DIRECTED[i].val, DIRECTED[i].sos, DIRECTED[i].has_exp, DIRECTED[i].exp);
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      await_drain();
      idle_on = 1'b1;
      if (ph == 0) begin
        cfg_write(REG_SLOPE, 8'hFF);
        cfg_write(REG_INTERCEPT, 8'hFF);
        cfg_write(REG_MODE, 8'hFF);
      end else if (ph == 1) begin
        cfg_write(REG_SLOPE, 8'h00);
        cfg_write(REG_INTERCEPT, 8'h00);
        cfg_write(REG_MODE, 8'h00);
      end else begin
        cfg_write(REG_SLOPE, 8'($urandom_range(255)));
        cfg_write(REG_INTERCEPT, 8'($urandom_range(255)));
        cfg_write(REG_MODE, 8'($urandom_range(255)));
        if ($urandom_range(1) == 1) cfg_write(REG_NONE, 8'($urandom_range(255)));
      end
      // phase 3: one long stream with no gaps and no stalls, wrapping the position
      idle_on = (ph != 3);
      total = (ph == 3) ? 300 : 35;
      sent = 0;
      while (sent < total) begin
        len = (ph == 3) ? total : $urandom_range(12, 1);
        noisy = ($urandom_range(9) == 0);
        for (int j = 0; j < len && sent < total; j++) begin
          sos = noisy ? 1'($urandom_range(1)) : (j == 0);
          push_byte(8'($urandom_range(255)), sos, 1'b0, 8'h00);
          sent++;
        end
      end
    end

    idle_on = 1'b1;
    await_drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
